/* sv/pws_pkg.sv */
package pws_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);

    localparam int IDX_W   = 10;
    localparam int DT_W    = 16;
    localparam int RAND_W  = 16;
    localparam int CFG_W   = 31;
    localparam int Q_W     = 32;
    localparam int CADDR_W = 2;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    // Configuration register indexes.
    localparam logic [CADDR_W-1:0] REG_X_VARIANCE = 2'd0;
    localparam logic [CADDR_W-1:0] REG_Y_VARIANCE = 2'd1;
    localparam logic [CADDR_W-1:0] REG_PACE       = 2'd2;

    // Operation codes carried in tuser.
    localparam logic OP_AFFECT = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic signed [Q_W-1:0] vel_x;
        logic signed [Q_W-1:0] vel_y;
        logic        [Q_W-1:0] peak_x;
        logic        [Q_W-1:0] peak_y;
        logic signed [Q_W-1:0] accel_x;
        logic signed [Q_W-1:0] accel_y;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic load;
        logic calc1;
        logic calc2;
    } t_axis_ctl;

endpackage

/* sv/pws_state_ram.sv */
module pws_state_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pws_axis.sv */
module pws_axis (
    input  logic                             i_clk,
    input  pws_pkg::t_axis_ctl               i_ctl,
    input  logic [pws_pkg::CFG_W-1:0]        i_variance,
    input  logic [pws_pkg::CFG_W-1:0]        i_pace,
    input  logic [pws_pkg::RAND_W-1:0]       i_rand_init,
    input  logic [pws_pkg::RAND_W-1:0]       i_rand_peak,
    input  logic [pws_pkg::DT_W-1:0]         i_dt,
    input  logic                             i_entry_valid,
    input  logic signed [pws_pkg::Q_W-1:0]   i_vel,
    input  logic [pws_pkg::Q_W-1:0]          i_peak,
    input  logic signed [pws_pkg::Q_W-1:0]   i_accel,
    output logic signed [pws_pkg::Q_W-1:0]   o_vel,
    output logic [pws_pkg::Q_W-1:0]          o_peak,
    output logic signed [pws_pkg::Q_W-1:0]   o_accel,
    output logic signed [pws_pkg::Q_W-1:0]   o_offset
);
    import pws_pkg::*;

    localparam int FRAC_W = CFG_W + RAND_W;
    localparam int PROD_W = Q_W + DT_W + 1;

    logic [DT_W-1:0]          r_dt;
    logic [CFG_W-1:0]         r_init_acc;
    logic [Q_W-1:0]           r_peak_draw;
    logic signed [Q_W-1:0]    r_vel;
    logic [Q_W-1:0]           r_peak;
    logic signed [Q_W-1:0]    r_accel;
    logic signed [PROD_W-1:0] r_adt;
    logic signed [PROD_W-1:0] r_vdt;

    logic [FRAC_W-1:0]        init_prod;
    logic [FRAC_W-1:0]        peak_prod;
    logic                     enabled;
    logic signed [Q_W-1:0]    sel_vel;
    logic [Q_W-1:0]           sel_peak;
    logic signed [Q_W-1:0]    sel_accel;
    logic signed [Q_W+1:0]    vel_w;
    logic signed [Q_W+1:0]    peak_w;
    logic                     flip;
    logic signed [Q_W-1:0]    n_accel;
    logic [Q_W-1:0]           n_peak;
    logic signed [Q_W-1:0]    adt_floor;
    logic signed [Q_W:0]      vel_sum;
    logic signed [Q_W-1:0]    n_vel;

    assign init_prod = FRAC_W'(i_pace) * FRAC_W'(i_rand_init);
    assign peak_prod = FRAC_W'(i_variance) * FRAC_W'(i_rand_peak);
    assign enabled   = (i_variance != '0);

    // A fresh entry starts at rest, with the peak at the variance.
    assign sel_vel   = i_entry_valid ? i_vel   : '0;
    assign sel_peak  = i_entry_valid ? i_peak  : {1'b0, i_variance};
    assign sel_accel = i_entry_valid ? i_accel : $signed({1'b0, r_init_acc});

    assign vel_w  = {{2{sel_vel[Q_W-1]}}, sel_vel};
    assign peak_w = $signed({2'b00, sel_peak});

    assign flip = enabled &&
                  (((vel_w > peak_w) && !sel_accel[Q_W-1] && (sel_accel != '0)) ||
                   ((vel_w < -peak_w) && sel_accel[Q_W-1]));

    assign n_accel = flip ? -sel_accel : sel_accel;
    assign n_peak  = flip ? r_peak_draw : sel_peak;

    // Arithmetic shift of the product is the floor of the division by 65536.
    assign adt_floor = r_adt[Q_W+DT_W-1:DT_W];
    assign vel_sum   = {r_vel[Q_W-1], r_vel} + {adt_floor[Q_W-1], adt_floor};

    always_comb begin
        n_vel = vel_sum[Q_W-1:0];
        if (vel_sum[Q_W] != vel_sum[Q_W-1]) begin
            n_vel = vel_sum[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        if (!enabled) begin
            n_vel = r_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dt        <= i_dt;
            r_init_acc  <= init_prod[FRAC_W-1:RAND_W];
            r_peak_draw <= {1'b0, i_variance} + {{(Q_W-CFG_W){1'b0}},
                                                 peak_prod[FRAC_W-1:RAND_W]};
        end
        if (i_ctl.calc1) begin
            r_vel   <= sel_vel;
            r_peak  <= n_peak;
            r_accel <= n_accel;
            r_adt   <= PROD_W'(n_accel) * $signed({{(PROD_W-DT_W){1'b0}}, r_dt});
        end
        if (i_ctl.calc2) begin
            r_vdt <= PROD_W'(n_vel) * $signed({{(PROD_W-DT_W){1'b0}}, r_dt});
        end
    end

    assign o_vel    = n_vel;
    assign o_peak   = r_peak;
    assign o_accel  = r_accel;
    assign o_offset = r_vdt[Q_W+DT_W-1:DT_W];

endmodule

/* sv/particle_wander_step.sv */
// An accepted word passes through S_CALC1, S_CALC2 and S_OUT; m_axis_tvalid rises
// when S_OUT loads the output register. A new word is taken only in S_IDLE, once the
// read, update and write-back sequence on the state memory is done; a stalled output
// holds the sequence in its last step. Reset: synchronous, active low. A clearing pass
// then marks all MAX_PARTICLES (1024) entries invalid while s_axis_tready is low;
// configuration writes are taken throughout, and those registers reset to zero.
module particle_wander_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pws_pkg::CADDR_W-1:0]       i_cfg_addr,
    input  logic [pws_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // particle_index, dt, rand_init_x, rand_init_y, rand_peak_x, rand_peak_y, zero pad
    input  logic [pws_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // dx, dy
    output logic [pws_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import pws_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CALC1 = 5'b00100,
        S_CALC2 = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [CFG_W-1:0]       r_x_variance;
    logic [CFG_W-1:0]       r_y_variance;
    logic [CFG_W-1:0]       r_pace;
    logic                   r_op;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_in_range;
    logic                   r_m_valid;
    logic [M_TDATA_W-1:0]   r_m_data;

    logic [IDX_W-1:0]       in_idx;
    logic [DT_W-1:0]        in_dt;
    logic [RAND_W-1:0]      in_rix;
    logic [RAND_W-1:0]      in_riy;
    logic [RAND_W-1:0]      in_rpx;
    logic [RAND_W-1:0]      in_rpy;
    logic                   accept;
    logic                   out_load;
    t_axis_ctl              axis_ctl;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]       ram_wdata;
    logic [ROW_W-1:0]       ram_rdata;
    t_row                   rd_row;
    t_row                   wr_row;

    logic signed [Q_W-1:0]  vel_x;
    logic signed [Q_W-1:0]  vel_y;
    logic [Q_W-1:0]         peak_x;
    logic [Q_W-1:0]         peak_y;
    logic signed [Q_W-1:0]  accel_x;
    logic signed [Q_W-1:0]  accel_y;
    logic signed [Q_W-1:0]  off_x;
    logic signed [Q_W-1:0]  off_y;

    assign in_idx = s_axis_tdata[IDX_W-1:0];
    assign in_dt  = s_axis_tdata[IDX_W+DT_W-1:IDX_W];
    assign in_rix = s_axis_tdata[IDX_W+DT_W+RAND_W-1:IDX_W+DT_W];
    assign in_riy = s_axis_tdata[IDX_W+DT_W+2*RAND_W-1:IDX_W+DT_W+RAND_W];
    assign in_rpx = s_axis_tdata[IDX_W+DT_W+3*RAND_W-1:IDX_W+DT_W+2*RAND_W];
    assign in_rpy = s_axis_tdata[IDX_W+DT_W+4*RAND_W-1:IDX_W+DT_W+3*RAND_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign axis_ctl.load  = accept;
    assign axis_ctl.calc1 = (r_state == S_CALC1);
    assign axis_ctl.calc2 = (r_state == S_CALC2);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_variance <= '0;
            r_y_variance <= '0;
            r_pace       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_X_VARIANCE: r_x_variance <= i_cfg_wdata;
                REG_Y_VARIANCE: r_y_variance <= i_cfg_wdata;
                REG_PACE:       r_pace       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer. Only one word is in flight, so the write-back always lands before
    // the next read of the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(MAX_PARTICLES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CALC1;
                    end
                end
                S_CALC1: r_state <= S_CALC2;
                S_CALC2: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= s_axis_tuser;
            r_idx      <= in_idx;
            r_in_range <= (32'(in_idx) < MAX_PARTICLES);
        end
    end

    assign rd_row = t_row'(ram_rdata);

    always_comb begin
        wr_row.valid   = (r_op == OP_AFFECT);
        wr_row.vel_x   = vel_x;
        wr_row.vel_y   = vel_y;
        wr_row.peak_x  = peak_x;
        wr_row.peak_y  = peak_y;
        wr_row.accel_x = accel_x;
        wr_row.accel_y = accel_y;
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(r_idx);
        ram_wdata = ROW_W'(wr_row);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_CALC2) begin
            ram_we = r_in_range;
        end
    end

    pws_state_ram #(
        .DEPTH (MAX_PARTICLES),
        .WIDTH (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ADDR_W'(in_idx)),
        .o_rdata (ram_rdata)
    );

    pws_axis u_axis_x (
        .i_clk         (i_clk),
        .i_ctl         (axis_ctl),
        .i_variance    (r_x_variance),
        .i_pace        (r_pace),
        .i_rand_init   (in_rix),
        .i_rand_peak   (in_rpx),
        .i_dt          (in_dt),
        .i_entry_valid (rd_row.valid),
        .i_vel         (rd_row.vel_x),
        .i_peak        (rd_row.peak_x),
        .i_accel       (rd_row.accel_x),
        .o_vel         (vel_x),
        .o_peak        (peak_x),
        .o_accel       (accel_x),
        .o_offset      (off_x)
    );

    pws_axis u_axis_y (
        .i_clk         (i_clk),
        .i_ctl         (axis_ctl),
        .i_variance    (r_y_variance),
        .i_pace        (r_pace),
        .i_rand_init   (in_riy),
        .i_rand_peak   (in_rpy),
        .i_dt          (in_dt),
        .i_entry_valid (rd_row.valid),
        .i_vel         (rd_row.vel_y),
        .i_peak        (rd_row.peak_y),
        .i_accel       (rd_row.accel_y),
        .o_vel         (vel_y),
        .o_peak        (peak_y),
        .o_accel       (accel_y),
        .o_offset      (off_y)
    );

    // Output register; a reset word or an index past the table answers zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if ((r_op == OP_RESET) || !r_in_range) begin
                r_m_data <= '0;
            end else begin
                r_m_data <= {off_y, off_x};
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CALC1))
        else $error("accepted word did not start the update sequence");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output step");

    a_reset_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_op == OP_RESET)) |=> (m_axis_tdata == '0))
        else $error("reset word gave a nonzero offset");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !ram_we)
        else $error("state memory written outside clear or write-back");

endmodule
